// ===== src/tss_pkg.sv =====
// Shared constants, item type and UTF-8 helpers for the text scramble selector.
// No dependencies; imported by tss_hash and text_scramble_selector.
package tss_pkg;

    // Hash mixing constants
    localparam logic [63:0] GOLDEN     = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;
    localparam logic [63:0] SALT_SUBST = 64'h0000_0000_0000_5555;
    localparam logic [63:0] SALT_POOL  = 64'h0000_0000_0000_aaaa;

    // Q1.16 one
    localparam logic [16:0] Q16_ONE = 17'h1_0000;

    // Operation codes
    localparam logic OP_POOL_WRITE = 1'b0;
    localparam logic OP_POSITION   = 1'b1;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_SEED       = 3'd0;
    localparam logic [2:0] REG_FRAME      = 3'd1;
    localparam logic [2:0] REG_MIX        = 3'd2;
    localparam logic [2:0] REG_INTENSITY  = 3'd3;
    localparam logic [2:0] REG_POOL_COUNT = 3'd4;

    // UTF-8 marker bits
    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    typedef struct packed {
        logic        operation;
        logic [15:0] position;
        logic [20:0] prev_code;
        logic        prev_present;
        logic [20:0] next_code;
        logic        next_present;
        logic [7:0]  pool_slot;
        logic [20:0] pool_code;
    } item_t;

    // Index of the final byte of the encoding (byte count minus one)
    function automatic logic [1:0] utf8_last(input logic [20:0] cp);
        logic [1:0] n;
        priority if (cp < 21'h00_0080) n = 2'd0;
        else if (cp < 21'h00_0800) n = 2'd1;
        else if (cp < 21'h01_0000) n = 2'd2;
        else n = 2'd3;
        return n;
    endfunction

    // Byte k of the encoding whose final byte index is last
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] last,
                                             input logic [1:0] k);
        logic [1:0] d;
        logic [5:0] cont;
        logic [7:0] b;
        d = last - k;
        unique case (d)
            2'd0:    cont = cp[5:0];
            2'd1:    cont = cp[11:6];
            2'd2:    cont = cp[17:12];
            default: cont = 6'd0;
        endcase
        if (k != 2'd0)
        begin
            b = UTF8_CONT | {2'b00, cont};
        end
        else
        begin
            unique case (last)
                2'd0: b = {1'b0, cp[6:0]};
                2'd1: b = UTF8_LEAD2 | {3'b000, cp[10:6]};
                2'd2: b = UTF8_LEAD3 | {4'b0000, cp[15:12]};
                2'd3: b = UTF8_LEAD4 | {5'b00000, cp[20:18]};
            endcase
        end
        return b;
    endfunction

endpackage

// ===== src/tss_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tss_ram #(
    parameter int WIDTH  = 21,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/tss_hash.sv =====
// Five-stage pipelined 64-bit position hash, returning the top 16 bits.
// Depends on tss_pkg for the mixing constants.
module tss_hash
    import tss_pkg::*;
(
    input  logic        clk,
    input  logic        adv,
    input  logic [63:0] seed_val,
    input  logic [63:0] hash_index,
    output logic [15:0] top16
);

    logic [63:0] k_reg;
    logic [63:0] x1_next;
    logic [63:0] y1_reg;
    logic [63:0] pa_ll_reg;
    logic [31:0] pa_hl_reg;
    logic [31:0] pa_lh_reg;
    logic [63:0] x2_next;
    logic [63:0] y2_reg;
    logic [63:0] pb_ll_reg;
    logic [31:0] pb_hl_reg;
    logic [31:0] pb_lh_reg;
    logic [63:0] x3_next;
    logic [63:0] h_next;
    logic [15:0] top_reg;

    // Seed-only term of the first mixing step, kept current from the seed
    always_ff @(posedge clk)
    begin
        k_reg <= GOLDEN + (seed_val << 6) + (seed_val >> 2);
    end

    always_comb
    begin
        x1_next = seed_val ^ (hash_index + k_reg);
        x2_next = pa_ll_reg + {pa_hl_reg + pa_lh_reg, 32'h0};
        x3_next = pb_ll_reg + {pb_hl_reg + pb_lh_reg, 32'h0};
        h_next  = x3_next ^ (x3_next >> 31);
    end

    // Advance the hash stages; each 64x64 product is split into 32-bit partials
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y1_reg    <= x1_next ^ (x1_next >> 30);
            pa_ll_reg <= 64'(y1_reg[31:0]) * 64'(MIX_MUL_A[31:0]);
            pa_hl_reg <= y1_reg[63:32] * MIX_MUL_A[31:0];
            pa_lh_reg <= y1_reg[31:0] * MIX_MUL_A[63:32];
            y2_reg    <= x2_next ^ (x2_next >> 27);
            pb_ll_reg <= 64'(y2_reg[31:0]) * 64'(MIX_MUL_B[31:0]);
            pb_hl_reg <= y2_reg[63:32] * MIX_MUL_B[31:0];
            pb_lh_reg <= y2_reg[31:0] * MIX_MUL_B[63:32];
            top_reg   <= h_next[63:48];
        end
    end

    assign top16 = top_reg;

endmodule

// ===== src/text_scramble_selector.sv =====
// Text scramble selector: per-position codepoint choice, pool substitution
// and UTF-8 serialization. Depends on tss_pkg, tss_hash and tss_ram.
//
// Usage:
//  - Configuration is an APB slave, 64-bit data, registers at 8-byte steps:
//    seed, frame number, mix, intensity, pool count. Write only when idle.
//  - The input channel (in_valid / in_stall) takes one item per cycle while in_stall is low. An
//    item either writes one pool entry or processes one character position.
//  - The output channel (out_valid / out_stall) moves one UTF-8 byte per
//    item; last_byte marks the final byte of a position. A position yields
//    zero to four bytes, so the output byte rate of one per cycle, while
//    out_stall is low, sets the sustained rate of positions at the intake.
//  - From acceptance to the first byte, an item passes the intake stages,
//    five hash stages, the pool memory read stage and the byte serializer.
//    Pool writes reach the memory from the same stage as pool reads, in
//    order with them, so a later position always sees the new entry.
//  - While a position with bytes waits at the last stage and the serializer
//    is still busy, the whole pipeline holds and in_stall is high, however
//    many stages behind it are empty. An output stall extends that hold.
//  - Reset clears the configuration registers and the valid flags, emptying
//    the pipeline; the pool memory is undefined until written and needs no clearing pass.
module text_scramble_selector
    import tss_pkg::*;
#(
    parameter int POOL_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [15:0] position,
    input  logic [20:0] prev_code,
    input  logic        prev_present,
    input  logic [20:0] next_code,
    input  logic        next_present,
    input  logic [7:0]  pool_slot,
    input  logic [20:0] pool_code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last_byte
);

    localparam int AW     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW     = $clog2(POOL_DEPTH + 1);
    localparam int SLOT_W = (AW > 8) ? AW : 8;
    localparam int PW     = 16 + CW;

    // Configuration registers
    logic [63:0] seed_reg;
    logic [63:0] frame_reg;
    logic [16:0] mix_reg;
    logic [16:0] intens_reg;
    logic [8:0]  count_reg;
    logic        cfg_wr;

    // Values derived from configuration
    logic [63:0]    fg_ll_reg;
    logic [31:0]    fg_hl_reg;
    logic [31:0]    fg_lh_reg;
    logic [33:0]    m1_reg;
    logic [50:0]    p_prod;
    logic [52:0]    p_reg;
    logic [CW-1:0]  cnt_sat_next;
    logic [CW-1:0]  cnt_sat_reg;

    // Pipeline
    logic        adv;
    logic [8:0]  v_reg;
    item_t       pipe_reg [8];
    logic [63:0] idx_next;
    logic [63:0] idx_reg;
    logic [15:0] h1_top;
    logic [15:0] h2_top;
    logic [15:0] h3_top;

    // Selection stage
    item_t          it7;
    logic           pick_next;
    logic           subst_hit;
    logic           general;
    logic [20:0]    sel_code;
    logic           sel_emit;
    logic [PW-1:0]  pool_prod;
    logic [CW-1:0]  pool_addr;
    logic [SLOT_W-1:0] slot_ext;
    logic           slot_ok;
    logic           ram_we;
    logic           ram_re;
    logic [20:0]    pool_rdata;
    logic [20:0]    cp8_reg;
    logic           emit8_reg;
    logic           subst8_reg;

    // Byte serializer
    logic [20:0] cp_final;
    logic        load;
    logic        out_acc;
    logic        ser_done;
    logic        ser_free;
    logic        ser_v_reg;
    logic        ser_v_next;
    logic [20:0] ser_cp_reg;
    logic [1:0]  ser_last_reg;
    logic [1:0]  ser_k_reg;
    logic [1:0]  ser_k_next;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg   <= '0;
            frame_reg  <= '0;
            mix_reg    <= '0;
            intens_reg <= '0;
            count_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[5:3])
                REG_SEED:       seed_reg   <= pwdata;
                REG_FRAME:      frame_reg  <= pwdata;
                REG_MIX:        mix_reg    <= pwdata[16:0];
                REG_INTENSITY:  intens_reg <= pwdata[16:0];
                REG_POOL_COUNT: count_reg  <= pwdata[8:0];
                default:
                begin
                end
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (paddr[5:3])
            REG_SEED:       prdata = seed_reg;
            REG_FRAME:      prdata = frame_reg;
            REG_MIX:        prdata = 64'(mix_reg);
            REG_INTENSITY:  prdata = 64'(intens_reg);
            REG_POOL_COUNT: prdata = 64'(count_reg);
            default:        prdata = '0;
        endcase
    end

    // Keep frame product, substitution threshold and saturated count current
    assign p_prod       = 51'(intens_reg) * 51'(m1_reg);
    assign cnt_sat_next = (32'(count_reg) > 32'(POOL_DEPTH)) ? CW'(POOL_DEPTH)
                                                              : CW'(count_reg);

    always_ff @(posedge clk)
    begin
        fg_ll_reg   <= 64'(frame_reg[31:0]) * 64'(GOLDEN[31:0]);
        fg_hl_reg   <= frame_reg[63:32] * GOLDEN[31:0];
        fg_lh_reg   <= frame_reg[31:0] * GOLDEN[63:32];
        m1_reg      <= 34'(mix_reg) * 34'(Q16_ONE - mix_reg);
        p_reg       <= {p_prod, 2'b00};
        cnt_sat_reg <= cnt_sat_next;
    end

    // Global advance: the pipeline moves unless its last stage must wait
    assign adv      = !(v_reg[8] && emit8_reg) || ser_free;
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[7:0], in_valid};
        end
    end

    // Hash index for the position, mixed with the frame product
    assign idx_next = {48'h0, pipe_reg[1].position}
                    ^ (fg_ll_reg + {fg_hl_reg + fg_lh_reg, 32'h0});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pipe_reg[0] <= '{operation, position, prev_code, prev_present, next_code,
                             next_present, pool_slot, pool_code};
            for (int i = 1; i < 8; i++)
            begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
            idx_reg <= idx_next;
        end
    end

    tss_hash u_hash_pick (
        .clk        (clk),
        .adv        (adv),
        .seed_val   (seed_reg),
        .hash_index (idx_reg),
        .top16      (h1_top)
    );

    tss_hash u_hash_subst (
        .clk        (clk),
        .adv        (adv),
        .seed_val   (seed_reg ^ SALT_SUBST),
        .hash_index (idx_reg),
        .top16      (h2_top)
    );

    tss_hash u_hash_pool (
        .clk        (clk),
        .adv        (adv),
        .seed_val   (seed_reg ^ SALT_POOL),
        .hash_index (idx_reg),
        .top16      (h3_top)
    );

    // Choose the codepoint and decide on substitution
    always_comb
    begin
        it7       = pipe_reg[7];
        pick_next = {1'b0, h1_top} < mix_reg;
        subst_hit = {5'b0, h2_top, 32'h0} < p_reg;
        general   = 1'b0;
        sel_code  = it7.next_code;
        sel_emit  = 1'b0;
        priority if (it7.operation != OP_POSITION)
        begin
            sel_emit = 1'b0;
        end
        else if (cnt_sat_reg == '0 || mix_reg[16])
        begin
            sel_code = it7.next_code;
            sel_emit = it7.next_present;
        end
        else if (mix_reg == '0)
        begin
            sel_code = it7.prev_code;
            sel_emit = it7.prev_present;
        end
        else
        begin
            general  = 1'b1;
            sel_emit = it7.next_present || it7.prev_present;
            priority if (pick_next && it7.next_present) sel_code = it7.next_code;
            else if (!pick_next && it7.prev_present) sel_code = it7.prev_code;
            else if (it7.next_present) sel_code = it7.next_code;
            else sel_code = it7.prev_code;
        end
    end

    // Pool memory access, writes and reads in item order at one stage
    assign pool_prod = PW'(h3_top) * PW'(cnt_sat_reg);
    assign pool_addr = pool_prod[PW-1:16];
    assign slot_ext  = SLOT_W'(it7.pool_slot);
    assign slot_ok   = 32'(it7.pool_slot) < 32'(POOL_DEPTH);
    assign ram_we    = adv && v_reg[7] && (it7.operation == OP_POOL_WRITE) && slot_ok;
    assign ram_re    = adv && v_reg[7] && general && subst_hit;

    tss_ram #(
        .WIDTH  (21),
        .DEPTH  (POOL_DEPTH),
        .ADDR_W (AW)
    ) u_pool (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_ext[AW-1:0]),
        .wdata (it7.pool_code),
        .re    (ram_re),
        .raddr (pool_addr[AW-1:0]),
        .rdata (pool_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cp8_reg    <= sel_code;
            emit8_reg  <= sel_emit;
            subst8_reg <= general && subst_hit;
        end
    end

    // Serialize the chosen codepoint one byte per accepted output item
    assign cp_final = subst8_reg ? pool_rdata : cp8_reg;
    assign out_acc  = ser_v_reg && !out_stall;
    assign ser_done = out_acc && (ser_k_reg == ser_last_reg);
    assign ser_free = !ser_v_reg || ser_done;
    assign load     = adv && v_reg[8] && emit8_reg;

    always_comb
    begin
        priority if (load)
        begin
            ser_v_next = 1'b1;
            ser_k_next = 2'd0;
        end
        else if (ser_done)
        begin
            ser_v_next = 1'b0;
            ser_k_next = ser_k_reg;
        end
        else if (out_acc)
        begin
            ser_v_next = 1'b1;
            ser_k_next = ser_k_reg + 2'd1;
        end
        else
        begin
            ser_v_next = ser_v_reg;
            ser_k_next = ser_k_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ser_v_reg <= 1'b0;
            ser_k_reg <= 2'd0;
        end
        else
        begin
            ser_v_reg <= ser_v_next;
            ser_k_reg <= ser_k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ser_cp_reg   <= cp_final;
            ser_last_reg <= utf8_last(cp_final);
        end
    end

    assign out_valid = ser_v_reg;
    assign out_byte  = utf8_byte(ser_cp_reg, ser_last_reg, ser_k_reg);
    assign last_byte = (ser_k_reg == ser_last_reg);

`ifndef SYNTHESIS
    // A codepoint in progress keeps its bytes coming
    a_codepoint_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_byte |=> out_valid)
        else $error("byte sequence broken before its last byte");

    // An empty serializer never holds the intake
    a_empty_takes_input: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("intake stalled with no byte waiting");

    // A finished position reaches the output starting at its first byte
    a_load_shows_byte: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[8] && emit8_reg && !in_stall |=> out_valid && (ser_k_reg == 2'd0))
        else $error("selected codepoint not loaded into serializer");

    // Pool reads stay below the saturated count
    a_pool_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |-> (pool_addr < cnt_sat_reg))
        else $error("pool index beyond pool count");
`endif

endmodule
